[sv/tfn_pkg.sv]
package tfn_pkg;

  // default geometry
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 14;

  // normalized magnitude width, sum of squares width, square root steps, output field width
  localparam int RW     = 30;
  localparam int SQ_W   = 2 * RW + 2;
  localparam int SQ_N   = RW + 1;
  localparam int NORM_W = 16;

  // lane flags that ride along the pipe
  typedef struct packed {
    logic [2:0] neg;
    logic       dg;
  } side_t;

endpackage

[sv/triangle_face_normal_unit.sv]
// Unit face normal of one triangle per beat. Edges B-A and C-B are crossed, the cross product
// is normalized so its largest magnitude sits in [2^29, 2^30), a pipelined integer square root
// gives the length, and three pipelined restoring dividers (one quotient bit per stage) give
// each component with FRAC_BITS fraction bits, rounded half away from zero and clamped to
// +/-min(2^FRAC_BITS, 32767). A zero cross product gives a zero normal with degenerate set.
// One beat is accepted every cycle while in_stall is low. Most of the pipe depth is the
// 31-step square root and the divider.
// The whole pipe holds while a result waits and out_stall is high.
module triangle_face_normal_unit #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tfn_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        in_a_x,
  input  logic signed [COORD_BITS-1:0]        in_a_y,
  input  logic signed [COORD_BITS-1:0]        in_a_z,
  input  logic signed [COORD_BITS-1:0]        in_b_x,
  input  logic signed [COORD_BITS-1:0]        in_b_y,
  input  logic signed [COORD_BITS-1:0]        in_b_z,
  input  logic signed [COORD_BITS-1:0]        in_c_x,
  input  logic signed [COORD_BITS-1:0]        in_c_y,
  input  logic signed [COORD_BITS-1:0]        in_c_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tfn_pkg::NORM_W-1:0]   out_normal_x,
  output logic signed [tfn_pkg::NORM_W-1:0]   out_normal_y,
  output logic signed [tfn_pkg::NORM_W-1:0]   out_normal_z,
  output logic                                out_degenerate
);
  import tfn_pkg::*;

  localparam int EW  = COORD_BITS + 1;
  localparam int PW  = 2 * EW;
  localparam int XW  = PW + 1;
  localparam int MW  = XW - 1;
  localparam int NW  = (MW > RW) ? MW : RW;
  localparam int NS  = $clog2(NW);
  localparam int QB  = FRAC_BITS + 1;
  localparam int DW  = RW + FRAC_BITS + 1;
  localparam int PRW = RW + 2;
  localparam int LIM = (FRAC_BITS >= 15) ? 32767 : (2 ** FRAC_BITS);

  logic en;
  logic out_valid_r;

  // whole pipe advances unless a finished beat is held
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // edges
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic                 va_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r[0] <= EW'(in_b_x) - EW'(in_a_x);
      e1_r[1] <= EW'(in_b_y) - EW'(in_a_y);
      e1_r[2] <= EW'(in_b_z) - EW'(in_a_z);
      e2_r[0] <= EW'(in_c_x) - EW'(in_b_x);
      e2_r[1] <= EW'(in_c_y) - EW'(in_b_y);
      e2_r[2] <= EW'(in_c_z) - EW'(in_b_z);
    end
    if (!rst_n) va_r <= 1'b0;
    else if (en) va_r <= in_valid;
  end

  // six partial products
  logic signed [PW-1:0] p_r [6];
  logic                 vb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e1_r[1] * e2_r[0];
    end
    if (!rst_n) vb_r <= 1'b0;
    else if (en) vb_r <= va_r;
  end

  // cross product
  logic signed [XW-1:0] x_r [3];
  logic                 vc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= XW'(p_r[0]) - XW'(p_r[1]);
      x_r[1] <= XW'(p_r[2]) - XW'(p_r[3]);
      x_r[2] <= XW'(p_r[4]) - XW'(p_r[5]);
    end
    if (!rst_n) vc_r <= 1'b0;
    else if (en) vc_r <= vb_r;
  end

  // magnitudes, signs, degenerate flag
  logic [2:0][NW-1:0] nm_r [0:NS];
  side_t              sn_r [0:NS];
  logic               vn_r [0:NS];
  logic [2:0][NW-1:0] mag_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = NW'(x_r[i][XW-1] ? MW'(-x_r[i]) : MW'(x_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_r[0]       <= mag_nxt;
      sn_r[0].neg   <= {x_r[2][XW-1], x_r[1][XW-1], x_r[0][XW-1]};
      sn_r[0].dg    <= ((mag_nxt[0] | mag_nxt[1] | mag_nxt[2]) == '0);
    end
    if (!rst_n) vn_r[0] <= 1'b0;
    else if (en) vn_r[0] <= vc_r;
  end

  // left normalize: the OR of the magnitudes shares the largest one's bit length
  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int AMT = 1 << (NS - 1 - k);
    logic [NW-1:0] orv;
    logic          sh;
    assign orv = nm_r[k][0] | nm_r[k][1] | nm_r[k][2];
    assign sh  = (orv[NW-1 -: AMT] == '0);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          nm_r[k+1][i] <= sh ? (nm_r[k][i] << AMT) : nm_r[k][i];
        end
        sn_r[k+1] <= sn_r[k];
      end
      if (!rst_n) vn_r[k+1] <= 1'b0;
      else if (en) vn_r[k+1] <= vn_r[k];
    end
  end

  // squares
  logic [2:0][RW-1:0]   re_r;
  logic [2*RW-1:0]      sq_r [3];
  side_t                se_r;
  logic                 ve_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        re_r[i] <= nm_r[NS][i][NW-1 -: RW];
        sq_r[i] <= nm_r[NS][i][NW-1 -: RW] * nm_r[NS][i][NW-1 -: RW];
      end
      se_r <= sn_r[NS];
    end
    if (!rst_n) ve_r <= 1'b0;
    else if (en) ve_r <= vn_r[NS];
  end

  // sum of squares feeds the root
  logic [SQ_W-1:0]    sqs_r [0:SQ_N];
  logic [SQ_W-1:0]    sqq_r [0:SQ_N];
  logic [2:0][RW-1:0] rq_r  [0:SQ_N];
  side_t              sq_sd_r [0:SQ_N];
  logic               vq_r  [0:SQ_N];

  always_ff @(posedge clk) begin
    if (en) begin
      sqs_r[0]   <= SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]);
      sqq_r[0]   <= '0;
      rq_r[0]    <= re_r;
      sq_sd_r[0] <= se_r;
    end
    if (!rst_n) vq_r[0] <= 1'b0;
    else if (en) vq_r[0] <= ve_r;
  end

  // integer square root, one result bit per stage
  for (genvar t = 0; t < SQ_N; t++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_N - 1 - t));
    logic [SQ_W-1:0] trial;
    logic            take;
    assign trial = sqq_r[t] + BIT;
    assign take  = (sqs_r[t] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        sqs_r[t+1]   <= take ? (sqs_r[t] - trial) : sqs_r[t];
        sqq_r[t+1]   <= take ? ((sqq_r[t] >> 1) + BIT) : (sqq_r[t] >> 1);
        rq_r[t+1]    <= rq_r[t];
        sq_sd_r[t+1] <= sq_sd_r[t];
      end
      if (!rst_n) vq_r[t+1] <= 1'b0;
      else if (en) vq_r[t+1] <= vq_r[t];
    end
  end

  // dividends with the rounding half added
  logic [RW:0]        mg;
  logic [RW:0]        dm_r  [0:QB];
  logic [PRW-1:0]     dp_r  [0:QB][3];
  logic [QB-1:0]      dl_r  [0:QB][3];
  side_t              dsd_r [0:QB];
  logic               vd_r  [0:QB];
  logic [DW-1:0]      dv    [3];

  assign mg = sqq_r[SQ_N][RW:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv[i] = (DW'(rq_r[SQ_N][i]) << FRAC_BITS) + DW'(mg >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r[0] <= mg;
      for (int i = 0; i < 3; i++) begin
        dp_r[0][i] <= PRW'(dv[i] >> QB);
        dl_r[0][i] <= dv[i][QB-1:0];
      end
      dsd_r[0] <= sq_sd_r[SQ_N];
    end
    if (!rst_n) vd_r[0] <= 1'b0;
    else if (en) vd_r[0] <= vq_r[SQ_N];
  end

  // restoring divide, three lanes sharing the divisor, one quotient bit per stage
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [PRW-1:0] pt [3];
    logic           ge [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        pt[i] = {dp_r[j][i][PRW-2:0], dl_r[j][i][QB-1]};
        ge[i] = (pt[i] >= PRW'(dm_r[j]));
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dm_r[j+1] <= dm_r[j];
        for (int i = 0; i < 3; i++) begin
          dp_r[j+1][i] <= ge[i] ? (pt[i] - PRW'(dm_r[j])) : pt[i];
          dl_r[j+1][i] <= {dl_r[j][i][QB-2:0], ge[i]};
        end
        dsd_r[j+1] <= dsd_r[j];
      end
      if (!rst_n) vd_r[j+1] <= 1'b0;
      else if (en) vd_r[j+1] <= vd_r[j];
    end
  end

  // clamp, apply sign, output register
  logic signed [NORM_W-1:0] n_nxt [3];
  logic signed [NORM_W-1:0] n_r   [3];
  logic                     dg_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [QB-1:0]     qv;
      logic [NORM_W-1:0] qm;
      qv = dl_r[QB][i];
      qm = (qv > QB'(LIM)) ? NORM_W'(LIM) : NORM_W'(qv);
      if (dsd_r[QB].dg) n_nxt[i] = '0;
      else if (dsd_r[QB].neg[i]) n_nxt[i] = -$signed(qm);
      else n_nxt[i] = $signed(qm);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) n_r[i] <= n_nxt[i];
      dg_r <= dsd_r[QB].dg;
    end
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vd_r[QB];
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = n_r[0];
  assign out_normal_y   = n_r[1];
  assign out_normal_z   = n_r[2];
  assign out_degenerate = dg_r;

endmodule
